FILE: rtl/ufq_pkg.sv
// types and sizing constants for the two-class request queue
// no dependencies; imported by every module of the block
package ufq_pkg;

    localparam int URGENT_DEPTH  = 16;
    localparam int REGULAR_DEPTH = 16;
    localparam int ID_BITS       = 16;

    localparam int REQ_ID_W = 16;
    localparam int YEAR_W   = 12;
    localparam int TOTAL_W  = 6;

    // stored handle width: the request field never carries more than 16 bits
    localparam int ID_W  = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
    localparam int U_AW  = $clog2(URGENT_DEPTH);
    localparam int R_AW  = $clog2(REGULAR_DEPTH);
    localparam int U_CW  = $clog2(URGENT_DEPTH + 1);
    localparam int R_CW  = $clog2(REGULAR_DEPTH + 1);
    localparam int SUM_W = ((U_CW > R_CW) ? U_CW : R_CW) + 1;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVE   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [REQ_ID_W-1:0] request_id;
        logic [YEAR_W-1:0] year_key;
        logic              urgent;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [REQ_ID_W-1:0] served_id;
        logic [YEAR_W-1:0]   served_year;
        logic                served_urgent;
        logic [TOTAL_W-1:0]  waiting_total;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [YEAR_W-1:0] year;
    } t_reg_entry;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
    } t_fifo_req;

    typedef struct packed {
        logic [U_CW-1:0] count;
        logic [ID_W-1:0] head_id;
    } t_fifo_stat;

    typedef struct packed {
        logic       ins;
        logic       pop;
        t_reg_entry entry;
    } t_store_req;

    typedef struct packed {
        logic            done;
        logic [R_CW-1:0] count;
        t_reg_entry      entry;
    } t_store_stat;

endpackage

FILE: rtl/ufq_urgent_fifo.sv
// urgent class: circular fifo of handles in a memory with a registered read port
// depends on ufq_pkg
module ufq_urgent_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ufq_pkg::t_fifo_req  i_req,
    output ufq_pkg::t_fifo_stat o_stat
);
    import ufq_pkg::*;

    logic [ID_W-1:0] mem [URGENT_DEPTH];
    logic [ID_W-1:0] r_rdata;
    logic [U_AW-1:0] r_head, n_head;
    logic [U_AW-1:0] r_tail, n_tail;
    logic [U_CW-1:0] r_count, n_count;

    function automatic logic [U_AW-1:0] ptr_inc(input logic [U_AW-1:0] p);
        if (p == U_AW'(URGENT_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.push) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + 1'b1;
        end else if (i_req.pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[r_tail] <= i_req.id;
        end
        if (i_req.pop) begin
            r_rdata <= mem[r_head];
        end
    end

    assign o_stat.count   = r_count;
    assign o_stat.head_id = r_rdata;

endmodule

FILE: rtl/ufq_regular_store.sv
// regular class: circular buffer kept sorted by year, oldest first
// insert shifts larger entries up one slot per cycle; depends on ufq_pkg
module ufq_regular_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufq_pkg::t_store_req  i_req,
    output ufq_pkg::t_store_stat o_stat
);
    import ufq_pkg::*;

    localparam int SW = R_AW + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_LAST = 3'b100
    } t_st;

    t_reg_entry      mem [REGULAR_DEPTH];
    t_reg_entry      r_rdata;
    t_st             r_state, n_state;
    logic [R_AW-1:0] r_head, n_head;
    logic [R_CW-1:0] r_count, n_count;
    logic [R_AW-1:0] r_pos, n_pos;
    logic [R_CW-1:0] r_left, n_left;
    t_reg_entry      r_new, n_new;
    logic            r_done, n_done;

    logic            w_we;
    logic [R_AW-1:0] w_waddr;
    t_reg_entry      w_wdata;
    logic            w_re;
    logic [R_AW-1:0] w_raddr;
    logic [SW-1:0]   w_last_sum;
    logic [R_AW-1:0] w_last;

    function automatic logic [R_AW-1:0] ptr_inc(input logic [R_AW-1:0] p);
        if (p == R_AW'(REGULAR_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [R_AW-1:0] ptr_dec(input logic [R_AW-1:0] p);
        if (p == '0) begin
            return R_AW'(REGULAR_DEPTH - 1);
        end
        return p - 1'b1;
    endfunction

    // physical slot of the last stored entry
    assign w_last_sum = SW'(r_head) + SW'(r_count - 1'b1);
    assign w_last = (w_last_sum >= SW'(REGULAR_DEPTH))
                  ? R_AW'(w_last_sum - SW'(REGULAR_DEPTH))
                  : R_AW'(w_last_sum);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_pos   = r_pos;
        n_left  = r_left;
        n_new   = r_new;
        n_done  = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_new;
        w_re    = 1'b0;
        w_raddr = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.ins) begin
                    n_new   = i_req.entry;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        w_we    = 1'b1;
                        w_waddr = r_head;
                        w_wdata = i_req.entry;
                        n_done  = 1'b1;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = w_last;
                        n_pos   = w_last;
                        n_left  = r_count;
                        n_state = ST_CMP;
                    end
                end else if (i_req.pop) begin
                    w_re    = 1'b1;
                    w_raddr = r_head;
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                end
            end
            ST_CMP: begin
                w_we    = 1'b1;
                w_waddr = ptr_inc(r_pos);
                // strictly greater moves up: equal years keep arrival order
                if (r_rdata.year > r_new.year) begin
                    w_wdata = r_rdata;
                    if (r_left == R_CW'(1)) begin
                        n_state = ST_LAST;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = ptr_dec(r_pos);
                        n_pos   = ptr_dec(r_pos);
                        n_left  = r_left - 1'b1;
                    end
                end else begin
                    w_wdata = r_new;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_LAST: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_new;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_left <= n_left;
        r_new  <= n_new;
    end

    // read and write never hit the same slot in one cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;
    assign o_stat.entry = r_rdata;

endmodule

FILE: rtl/urgent_fifo_then_oldest_first_queue_top.sv
// top level of the two-class request queue: command decode and result register
// depends on ufq_pkg, ufq_urgent_fifo, ufq_regular_store
//
// One request at a time: a request is taken when start is high and busy is low,
// and its single result appears on o_rsp for exactly one cycle with o_strobe high;
// the receiver cannot stall it. An urgent enqueue, any rejected request and a serve
// that finds the queue empty give their result in the cycle after acceptance with busy
// never raised. Serving an urgent or regular entry reads the memory first, and the
// result is registered after that read. A regular enqueue into an empty store
// is written directly; into a non-empty store the sorted store moves one entry per
// cycle through its memory read and write ports until the new year's slot is found.
// busy stays high until the result shows.
module urgent_fifo_then_oldest_first_queue_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ufq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output ufq_pkg::t_rsp o_rsp
);
    import ufq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_UPOP  = 3'b010,
        S_RWAIT = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic        r_strobe, n_strobe;
    t_rsp        r_rsp, n_rsp;
    logic        r_pop, n_pop;
    logic [TOTAL_W-1:0] r_total, n_total;

    t_fifo_req   w_fifo_req;
    t_fifo_stat  w_fifo_stat;
    t_store_req  w_store_req;
    t_store_stat w_store_stat;

    logic             w_accept;
    logic [SUM_W-1:0] w_sum;
    logic             w_u_full;
    logic             w_r_full;

    ufq_urgent_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_fifo_req),
        .o_stat (w_fifo_stat)
    );

    ufq_regular_store u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_store_req),
        .o_stat (w_store_stat)
    );

    assign w_accept = start && (r_state == S_IDLE);
    assign w_sum    = SUM_W'(w_fifo_stat.count) + SUM_W'(w_store_stat.count);
    assign w_u_full = (w_fifo_stat.count >= U_CW'(URGENT_DEPTH));
    assign w_r_full = (w_store_stat.count >= R_CW'(REGULAR_DEPTH));

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        n_pop    = r_pop;
        n_total  = r_total;

        w_fifo_req        = '0;
        w_fifo_req.id     = i_req.request_id[ID_W-1:0];
        w_store_req       = '0;
        w_store_req.entry.id   = i_req.request_id[ID_W-1:0];
        w_store_req.entry.year = i_req.year_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rsp               = '0;
                    n_rsp.waiting_total = TOTAL_W'(w_sum);
                    if (i_req.cmd == CMD_ENQUEUE) begin
                        if (i_req.urgent) begin
                            if (!w_u_full) begin
                                w_fifo_req.push     = 1'b1;
                                n_rsp.ok            = 1'b1;
                                n_rsp.waiting_total = TOTAL_W'(w_sum + 1'b1);
                            end
                            n_strobe = 1'b1;
                        end else if (w_r_full) begin
                            n_strobe = 1'b1;
                        end else begin
                            w_store_req.ins = 1'b1;
                            n_pop           = 1'b0;
                            n_total         = TOTAL_W'(w_sum + 1'b1);
                            n_state         = S_RWAIT;
                        end
                    end else if (w_fifo_stat.count != '0) begin
                        w_fifo_req.pop = 1'b1;
                        n_total        = TOTAL_W'(w_sum - 1'b1);
                        n_state        = S_UPOP;
                    end else if (w_store_stat.count != '0) begin
                        w_store_req.pop = 1'b1;
                        n_pop           = 1'b1;
                        n_total         = TOTAL_W'(w_sum - 1'b1);
                        n_state         = S_RWAIT;
                    end else begin
                        // empty queue on serve
                        n_strobe = 1'b1;
                    end
                end
            end
            S_UPOP: begin
                n_rsp               = '0;
                n_rsp.ok            = 1'b1;
                n_rsp.served_id     = REQ_ID_W'(w_fifo_stat.head_id);
                n_rsp.served_urgent = 1'b1;
                n_rsp.waiting_total = r_total;
                n_strobe            = 1'b1;
                n_state             = S_IDLE;
            end
            S_RWAIT: begin
                if (w_store_stat.done) begin
                    n_rsp               = '0;
                    n_rsp.ok            = 1'b1;
                    n_rsp.waiting_total = r_total;
                    if (r_pop) begin
                        n_rsp.served_id   = REQ_ID_W'(w_store_stat.entry.id);
                        n_rsp.served_year = w_store_stat.entry.year;
                    end
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp   <= n_rsp;
        r_pop   <= n_pop;
        r_total <= n_total;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

FILE: rtl/ufq_checker.sv
// port-level checks for the two-class request queue, bound to the top level
// depends on ufq_pkg and urgent_fifo_then_oldest_first_queue_top
module ufq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input ufq_pkg::t_rsp o_rsp
);
    import ufq_pkg::*;

    // a result always closes out the request, so the next one can be taken
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    // an accepted request either answers at once or raises busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted request neither answered nor busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.ok) |->
            (o_rsp.served_id == '0 && o_rsp.served_year == '0 && !o_rsp.served_urgent))
        else $error("failed request carries served data");

    a_urgent_no_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.served_urgent) |-> (o_rsp.ok && o_rsp.served_year == '0))
        else $error("urgent serve with year or without ok");

endmodule

bind urgent_fifo_then_oldest_first_queue_top ufq_checker u_ufq_checker (.*);
